>>> rtl/ucf_pkg.sv
package ucf_pkg;

  localparam int MaxDelay = 4096;
  localparam int AddrW    = $clog2(MaxDelay);
  localparam int SampleW  = 16;
  localparam int GainW    = 16;
  localparam int DryW     = 15;
  localparam int LenW     = 13;
  localparam int ProdW    = SampleW + GainW;
  localparam int PaddrW   = 5;
  localparam int PdataW   = 32;

  localparam logic [DryW-1:0] DryMax    = DryW'(16384);
  localparam logic [LenW-1:0] LenMax    = LenW'(MaxDelay);
  localparam logic [LenW-1:0] LenMin    = LenW'(1);
  localparam int              RoundBias = 8192;
  localparam int              FracBits  = 14;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] RegFeedback    = 3'd0;
  localparam logic [2:0] RegFeedforward = 3'd1;
  localparam logic [2:0] RegMix         = 3'd2;
  localparam logic [2:0] RegDry         = 3'd3;
  localparam logic [2:0] RegDelayLen    = 3'd4;

  typedef struct packed {
    logic signed [GainW-1:0] fb;
    logic signed [GainW-1:0] ff;
    logic signed [GainW-1:0] mix;
    logic [DryW-1:0]         dry;
    logic [LenW-1:0]         len;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] xh;
    logic signed [SampleW-1:0] z;
  } mix_in_t;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [35:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ucf_ram.sv
module ucf_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ucf_regs.sv
module ucf_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ucf_pkg::PaddrW-1:0] paddr,
  input  logic [ucf_pkg::PdataW-1:0] pwdata,
  output logic [ucf_pkg::PdataW-1:0] prdata,
  output logic                      pready,
  output ucf_pkg::cfg_t             cfg_o
);
  import ucf_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             wr_en;
  logic [2:0]       idx;
  logic [DryW-1:0]  dry_in;
  logic [LenW-1:0]  len_in;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign dry_in = pwdata[DryW-1:0];
  assign len_in = pwdata[LenW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegFeedback:    cfg_d.fb  = pwdata[GainW-1:0];
        RegFeedforward: cfg_d.ff  = pwdata[GainW-1:0];
        RegMix:         cfg_d.mix = pwdata[GainW-1:0];
        RegDry:         cfg_d.dry = (dry_in > DryMax) ? DryMax : dry_in;
        RegDelayLen: begin
          if (len_in < LenMin) begin
            cfg_d.len = LenMin;
          end else if (len_in > LenMax) begin
            cfg_d.len = LenMax;
          end else begin
            cfg_d.len = len_in;
          end
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb  <= 16'sd16384;
      cfg_q.ff  <= '0;
      cfg_q.mix <= 16'sd16384;
      cfg_q.dry <= '0;
      cfg_q.len <= LenMin;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      RegFeedback:    prdata = PdataW'(unsigned'(cfg_q.fb));
      RegFeedforward: prdata = PdataW'(unsigned'(cfg_q.ff));
      RegMix:         prdata = PdataW'(unsigned'(cfg_q.mix));
      RegDry:         prdata = PdataW'(cfg_q.dry);
      RegDelayLen:    prdata = PdataW'(cfg_q.len);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/ucf_core.sv
module ucf_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ucf_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ucf_pkg::SampleW-1:0]  in_sample_i,
  input  logic                         item_free_i,
  output logic                         item_valid_o,
  output ucf_pkg::mix_in_t             item_o
);
  import ucf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic                      state_q, state_d;
  logic [AddrW-1:0]          wp_q;
  logic                      wrapped_q;
  logic signed [SampleW-1:0] last_q;
  logic signed [SampleW-1:0] x_q;
  logic signed [ProdW-1:0]   fbprod_q;
  logic                      zok_q;

  logic                      accept;
  logic                      done;
  logic [AddrW-1:0]          rd_addr;
  logic [SampleW-1:0]        rdata;
  logic signed [SampleW-1:0] z;
  logic signed [ProdW:0]     fb_sum;
  logic signed [19:0]        xh_wide;
  logic signed [SampleW-1:0] xh;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign done       = (state_q == S_RD) && item_free_i;

  // Read position trails the write pointer by the delay length, modulo the store depth.
  assign rd_addr = wp_q - cfg_i.len[AddrW-1:0];

  ucf_ram #(
    .Width(SampleW),
    .Depth(MaxDelay)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (done),
    .waddr_i(wp_q),
    .wdata_i(xh),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // Entries are written in address order from zero, so an entry holds data once the
  // pointer has passed it or wrapped; anything else is forced to read as zero.
  assign z = zok_q ? $signed(rdata) : '0;

  assign fb_sum  = (ProdW+1)'(fbprod_q) + (ProdW+1)'(RoundBias);
  assign xh_wide = 20'(x_q) + 20'(fb_sum >>> FracBits);
  assign xh      = sat16(36'(xh_wide));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_RD:   if (done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      last_q    <= '0;
      zok_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        zok_q <= wrapped_q || (rd_addr < wp_q);
      end
      if (done) begin
        wp_q   <= wp_q + AddrW'(1);
        last_q <= z;
        if (wp_q == '1) begin
          wrapped_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= $signed(in_sample_i);
      fbprod_q <= last_q * cfg_i.fb;
    end
  end

  assign item_valid_o = done;
  assign item_o.x     = x_q;
  assign item_o.xh    = xh;
  assign item_o.z     = z;

endmodule

>>> rtl/ucf_mix.sv
module ucf_mix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ucf_pkg::cfg_t               cfg_i,
  input  logic                        item_valid_i,
  input  ucf_pkg::mix_in_t            item_i,
  output logic                        item_free_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ucf_pkg::SampleW-1:0] out_sample_o
);
  import ucf_pkg::*;

  logic                      p1_v_q, p2_v_q, out_v_q;
  mix_in_t                   p1_q;
  logic signed [ProdW-1:0]   pff_q, pmix_q, pdry_q;
  logic signed [SampleW-1:0] y_q;

  logic                      out_free, p2_free, p1_free;
  logic                      p1_move, p2_move;
  logic signed [ProdW+1:0]   acc;
  logic signed [SampleW-1:0] y;

  assign out_free = !out_v_q || out_ready_i;
  assign p2_move  = p2_v_q && out_free;
  assign p2_free  = !p2_v_q || out_free;
  assign p1_move  = p1_v_q && p2_free;
  assign p1_free  = !p1_v_q || p2_free;

  assign acc = (ProdW+2)'(pff_q) + (ProdW+2)'(pmix_q) + (ProdW+2)'(pdry_q)
             + (ProdW+2)'(RoundBias);
  assign y   = sat16(36'(acc >>> FracBits));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (p1_free) p1_v_q <= item_valid_i;
      if (p2_free) p2_v_q <= p1_move;
      if (out_free) out_v_q <= p2_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i && p1_free) begin
      p1_q <= item_i;
    end
    if (p1_move) begin
      pff_q  <= p1_q.z * cfg_i.ff;
      pmix_q <= p1_q.xh * cfg_i.mix;
      pdry_q <= p1_q.x * $signed({1'b0, cfg_i.dry});
    end
    if (p2_move) begin
      y_q <= y;
    end
  end

  assign item_free_o  = p1_free;
  assign out_valid_o  = out_v_q;
  assign out_sample_o = y_q;

endmodule

>>> rtl/universal_comb_filter.sv
// Universal comb filter on a Q1.15 sample stream. Each input beat yields one output beat:
// the internal value is the input plus the Q2.14 feedback gain times the previous delayed
// sample, it is written into a delay line of 1 to 4096 samples held in one synchronous RAM,
// and the output is the saturated, rounded sum of feedforward gain times the delayed
// sample, mix gain times the internal value and dry gain times the input. The block takes
// a new sample only once the last one was read from the RAM and its feedback value written
// back, since the next sample needs the delayed sample just read. A result leaves through
// stallable input, multiply and output registers; the sum is formed before the last one.
// The delay line reads as zero until written, tracked by the write pointer and a wrap flag,
// so there is no clearing pass after reset. Registers sit on an APB port at byte addresses
// 0x00 feedback, 0x04 feedforward, 0x08 mix, 0x0C dry (clamped to 1.0) and 0x10 delay
// length (clamped to 1..4096); write them only while idle.
module universal_comb_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ucf_pkg::*;

  cfg_t    cfg;
  mix_in_t item;
  logic    item_valid;
  logic    item_free;

  ucf_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  ucf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .item_free_i (item_free),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  ucf_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_free_o (item_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sample_o(m_axis_tdata)
  );

endmodule
